// ----- hdl/cmm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmm_pkg
// shared types, codes and sizes for the console memory map with object dma
// ----------------------------------------------------------------------------
package cmm_pkg;

    // store sizes and copy start delay
    localparam int VRAM_BYTES      = 8192;
    localparam int WRAM_BYTES      = 8192;
    localparam int HRAM_BYTES      = 127;
    localparam int OAM_BYTES       = 160;
    localparam int DMA_START_DELAY = 2;

    localparam int VRAM_AW = $clog2(VRAM_BYTES);
    localparam int WRAM_AW = $clog2(WRAM_BYTES);
    localparam int HRAM_AW = $clog2(HRAM_BYTES);
    localparam int OAM_AW  = $clog2(OAM_BYTES);

    // clearing pass covers the deepest store
    localparam int CLR_BYTES = (VRAM_BYTES > WRAM_BYTES) ? VRAM_BYTES : WRAM_BYTES;
    localparam int CLR_AW    = $clog2(CLR_BYTES);

    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef enum logic [1:0] {
        FN_READ  = 2'd0,
        FN_WRITE = 2'd1,
        FN_TICK  = 2'd2,
        FN_NOP   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        TGT_NONE  = 3'd0,
        TGT_CART  = 3'd1,
        TGT_PAD   = 3'd2,
        TGT_TIMER = 3'd3,
        TGT_SOUND = 3'd4,
        TGT_WAVE  = 3'd5,
        TGT_LCD   = 3'd6
    } t_target;

    typedef enum logic [1:0] {
        ERR_OK          = 2'd0,
        ERR_ABSENT      = 2'd1,
        ERR_UNSUPPORTED = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        CFG_CART  = 2'd0,
        CFG_SOUND = 2'd1,
        CFG_LCD   = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        RG_EXT,
        RG_ABSENT,
        RG_VRAM,
        RG_WRAM,
        RG_OAM,
        RG_HRAM,
        RG_IE,
        RG_IF,
        RG_SER_DATA,
        RG_SER_CTRL,
        RG_DMA,
        RG_BAD
    } t_region;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    typedef struct packed {
        t_region region;
        t_target target;
    } t_decode;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  ext_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [2:0]  ext_target;
        logic        ext_write;
        logic [15:0] ext_address;
        logic [7:0]  ext_write_data;
        logic        dma_busy;
        logic [15:0] dma_source_address;
        logic [1:0]  error_code;
    } t_out_item;

endpackage
`default_nettype wire

// ----- hdl/cmm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmm_ram
// generic single-write, single-read synchronous ram with registered read
// ----------------------------------------------------------------------------
module cmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- hdl/cmm_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmm_decode
// bus address decoder: local region or external unit with presence check
// ----------------------------------------------------------------------------
module cmm_decode
    import cmm_pkg::*;
(
    input  wire logic [15:0] i_addr,
    input  wire logic        i_cart_att,
    input  wire logic        i_sound_att,
    input  wire logic        i_lcd_att,
    output t_decode          o_dec
);

    logic [15:0] w_hram_off;

    assign w_hram_off = i_addr - 16'hFF80;

    always_comb begin
        o_dec.region = RG_BAD;
        o_dec.target = TGT_NONE;
        // external units first
        if (i_addr inside {[16'h0000:16'h7FFF], [16'hA000:16'hBFFF]}) begin
            o_dec.region = i_cart_att ? RG_EXT : RG_ABSENT;
            o_dec.target = TGT_CART;
        end else if (i_addr == 16'hFF00) begin
            o_dec.region = RG_EXT;
            o_dec.target = TGT_PAD;
        end else if (i_addr inside {[16'hFF04:16'hFF07]}) begin
            o_dec.region = RG_EXT;
            o_dec.target = TGT_TIMER;
        end else if (i_addr inside {[16'hFF10:16'hFF26]}) begin
            o_dec.region = i_sound_att ? RG_EXT : RG_ABSENT;
            o_dec.target = TGT_SOUND;
        end else if (i_addr inside {[16'hFF30:16'hFF3F]}) begin
            o_dec.region = i_sound_att ? RG_EXT : RG_ABSENT;
            o_dec.target = TGT_WAVE;
        end else if (i_addr inside {[16'hFF40:16'hFF4B]} && i_addr != 16'hFF46) begin
            o_dec.region = i_lcd_att ? RG_EXT : RG_ABSENT;
            o_dec.target = TGT_LCD;
        // local stores and registers
        end else if (i_addr inside {[16'h8000:16'h9FFF]}) begin
            o_dec.region = RG_VRAM;
        end else if (i_addr inside {[16'hC000:16'hDFFF]}) begin
            o_dec.region = RG_WRAM;
        end else if (i_addr >= 16'hFE00 && i_addr < 16'(16'hFE00 + OAM_BYTES)) begin
            o_dec.region = RG_OAM;
        end else if (i_addr == 16'hFFFF) begin
            o_dec.region = RG_IE;
        end else if (i_addr >= 16'hFF80) begin
            o_dec.region = (w_hram_off < 16'(HRAM_BYTES)) ? RG_HRAM : RG_BAD;
        end else if (i_addr == 16'hFF01) begin
            o_dec.region = RG_SER_DATA;
        end else if (i_addr == 16'hFF02) begin
            o_dec.region = RG_SER_CTRL;
        end else if (i_addr == 16'hFF0F) begin
            o_dec.region = RG_IF;
        end else if (i_addr == 16'hFF46) begin
            o_dec.region = RG_DMA;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/console_memory_map_with_oam_dma.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// console_memory_map_with_oam_dma
// handheld console bus memory map with object-ram copy engine
//
// input channel (i_in_valid / o_in_stall, payload i_in_data) carries one bus
// read, bus write, copy tick or no-op per beat; output channel (o_out_valid /
// i_out_stall, payload o_out_data) returns exactly one result beat per input.
// config port: i_cfg_we with i_cfg_index picks cartridge, sound or lcd
// presence, bit 0 of i_cfg_wdata is the new value; takes effect at once.
// one beat at a time: accept, ram read, execute. the result register loads
// when the execute step fires, and the next beat is taken once the sequencer
// is back in idle; the read step is needed because the store rams (one write
// port, one read port each) give their read data from a register.
// output register lets a new beat enter while a result still waits; if the
// receiver stalls, the execute step waits with the ram data held.
// after reset a clearing pass writes zero through all stores, one entry a
// cycle, up to the depth of the deepest store; no beat is taken during it,
// config writes are.
// ----------------------------------------------------------------------------
module console_memory_map_with_oam_dma
    import cmm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // input beats
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    // result beats
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data,
    // configuration writes
    input  wire logic      i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic      i_cfg_wdata
);

    // control and small register state
    t_state          r_state, n_state;
    logic [CLR_AW-1:0] r_clr_cnt, n_clr_cnt;
    logic            r_out_valid, n_out_valid;
    logic            r_cart_att, r_sound_att, r_lcd_att;
    logic [7:0]      r_int_enable, n_int_enable;
    logic [7:0]      r_int_flags, n_int_flags;
    logic [7:0]      r_ser_data, n_ser_data;
    logic [7:0]      r_ser_ctrl, n_ser_ctrl;
    logic [7:0]      r_dma_page, n_dma_page;
    logic            r_dma_running, n_dma_running;
    logic [7:0]      r_dma_index, n_dma_index;
    logic [1:0]      r_dma_delay, n_dma_delay;

    // payload registers
    t_in_item        r_item;
    t_out_item       r_out_data, n_out_data;

    // datapath
    logic            w_clear;
    logic            w_done;
    logic            w_copy;
    logic            w_is_read, w_is_write;
    logic [15:0]     w_addr;
    t_decode         w_dec;
    logic [7:0]      w_rv_data;
    t_target         w_rv_tgt;
    t_err            w_rv_err;

    logic [7:0]      w_vram_q, w_wram_q, w_hram_q, w_oam_q;
    logic            w_vram_we, w_wram_we, w_hram_we, w_oam_we;
    logic [VRAM_AW-1:0] w_vram_waddr;
    logic [WRAM_AW-1:0] w_wram_waddr;
    logic [HRAM_AW-1:0] w_hram_waddr;
    logic [OAM_AW-1:0]  w_oam_waddr;
    logic [7:0]      w_cpu_wdata, w_oam_wdata;
    logic            w_re;

    assign w_clear    = (r_state == ST_CLEAR);
    assign w_is_read  = (r_item.func == FN_READ);
    assign w_is_write = (r_item.func == FN_WRITE);
    // execute step fires when the result register is free or drains now
    assign w_done     = (r_state == ST_EXEC) && (!r_out_valid || !i_out_stall);
    // a tick that moves a byte
    assign w_copy     = (r_item.func == FN_TICK) && r_dma_running && (r_dma_delay == 2'd0);
    // ticks address the copy source, everything else the bus address
    assign w_addr     = (r_item.func == FN_TICK) ? {r_dma_page, r_dma_index} : r_item.address;
    assign w_re       = (r_state == ST_READ);

    cmm_decode u_decode (
        .i_addr      (w_addr),
        .i_cart_att  (r_cart_att),
        .i_sound_att (r_sound_att),
        .i_lcd_att   (r_lcd_att),
        .o_dec       (w_dec)
    );

    // read view of the decoded address, shared by cpu reads and copy ticks
    always_comb begin
        w_rv_data = 8'h00;
        w_rv_tgt  = TGT_NONE;
        w_rv_err  = ERR_OK;
        case (w_dec.region)
            RG_EXT: begin
                w_rv_data = r_item.ext_data;
                w_rv_tgt  = w_dec.target;
            end
            RG_ABSENT: begin
                w_rv_data = BYTE_ONES;
                w_rv_err  = ERR_ABSENT;
            end
            RG_VRAM:     w_rv_data = w_vram_q;
            RG_WRAM:     w_rv_data = w_wram_q;
            RG_HRAM:     w_rv_data = w_hram_q;
            // object ram is locked while a copy runs
            RG_OAM:      w_rv_data = r_dma_running ? BYTE_ONES : w_oam_q;
            RG_IE:       w_rv_data = r_int_enable;
            RG_IF:       w_rv_data = r_int_flags;
            RG_SER_DATA: w_rv_data = r_ser_data;
            RG_SER_CTRL: w_rv_data = r_ser_ctrl;
            RG_DMA:      w_rv_data = r_dma_page;
            default:     w_rv_err  = ERR_UNSUPPORTED;
        endcase
    end

    // store write ports: clearing pass, cpu writes, copy into object ram
    always_comb begin
        w_cpu_wdata  = w_clear ? 8'h00 : r_item.write_data;
        w_vram_we    = (w_clear && (int'(r_clr_cnt) < VRAM_BYTES)) ||
                       (w_done && w_is_write && w_dec.region == RG_VRAM);
        w_wram_we    = (w_clear && (int'(r_clr_cnt) < WRAM_BYTES)) ||
                       (w_done && w_is_write && w_dec.region == RG_WRAM);
        w_hram_we    = (w_clear && (int'(r_clr_cnt) < HRAM_BYTES)) ||
                       (w_done && w_is_write && w_dec.region == RG_HRAM);
        w_oam_we     = (w_clear && (int'(r_clr_cnt) < OAM_BYTES)) ||
                       (w_done && w_is_write && w_dec.region == RG_OAM && !r_dma_running) ||
                       (w_done && w_copy && r_dma_index < 8'(OAM_BYTES));
        w_vram_waddr = w_clear ? r_clr_cnt[VRAM_AW-1:0] : w_addr[VRAM_AW-1:0];
        w_wram_waddr = w_clear ? r_clr_cnt[WRAM_AW-1:0] : w_addr[WRAM_AW-1:0];
        w_hram_waddr = w_clear ? r_clr_cnt[HRAM_AW-1:0] : w_addr[HRAM_AW-1:0];
        if (w_clear) begin
            w_oam_waddr = r_clr_cnt[OAM_AW-1:0];
            w_oam_wdata = 8'h00;
        end else if (w_copy) begin
            w_oam_waddr = r_dma_index[OAM_AW-1:0];
            w_oam_wdata = w_rv_data;
        end else begin
            w_oam_waddr = w_addr[OAM_AW-1:0];
            w_oam_wdata = r_item.write_data;
        end
    end

    cmm_ram #(.WIDTH(8), .DEPTH(VRAM_BYTES)) u_vram (
        .i_clk   (i_clk),
        .i_we    (w_vram_we),
        .i_waddr (w_vram_waddr),
        .i_wdata (w_cpu_wdata),
        .i_re    (w_re),
        .i_raddr (w_addr[VRAM_AW-1:0]),
        .o_rdata (w_vram_q)
    );

    cmm_ram #(.WIDTH(8), .DEPTH(WRAM_BYTES)) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_wram_we),
        .i_waddr (w_wram_waddr),
        .i_wdata (w_cpu_wdata),
        .i_re    (w_re),
        .i_raddr (w_addr[WRAM_AW-1:0]),
        .o_rdata (w_wram_q)
    );

    cmm_ram #(.WIDTH(8), .DEPTH(HRAM_BYTES)) u_hram (
        .i_clk   (i_clk),
        .i_we    (w_hram_we),
        .i_waddr (w_hram_waddr),
        .i_wdata (w_cpu_wdata),
        .i_re    (w_re),
        .i_raddr (w_addr[HRAM_AW-1:0]),
        .o_rdata (w_hram_q)
    );

    cmm_ram #(.WIDTH(8), .DEPTH(OAM_BYTES)) u_oam (
        .i_clk   (i_clk),
        .i_we    (w_oam_we),
        .i_waddr (w_oam_waddr),
        .i_wdata (w_oam_wdata),
        .i_re    (w_re),
        .i_raddr (w_addr[OAM_AW-1:0]),
        .o_rdata (w_oam_q)
    );

    // sequencer and execute step
    always_comb begin
        n_state       = r_state;
        n_clr_cnt     = r_clr_cnt;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_data    = r_out_data;
        n_int_enable  = r_int_enable;
        n_int_flags   = r_int_flags;
        n_ser_data    = r_ser_data;
        n_ser_ctrl    = r_ser_ctrl;
        n_dma_page    = r_dma_page;
        n_dma_running = r_dma_running;
        n_dma_index   = r_dma_index;
        n_dma_delay   = r_dma_delay;

        case (r_state)
            ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == CLR_AW'(CLR_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (w_done) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_data  = '0;

                    if (w_is_read) begin
                        n_out_data.read_data  = w_rv_data;
                        n_out_data.ext_target = w_rv_tgt;
                        n_out_data.error_code = w_rv_err;
                        if (w_rv_tgt != TGT_NONE) begin
                            n_out_data.ext_address = w_addr;
                        end
                    end else if (w_is_write) begin
                        case (w_dec.region)
                            RG_EXT: begin
                                n_out_data.ext_target     = w_dec.target;
                                n_out_data.ext_write      = 1'b1;
                                n_out_data.ext_address    = w_addr;
                                n_out_data.ext_write_data = r_item.write_data;
                            end
                            RG_ABSENT:   n_out_data.error_code = ERR_ABSENT;
                            RG_VRAM, RG_WRAM, RG_HRAM, RG_OAM: begin
                                // store write happens on the ram ports
                            end
                            RG_IE:       n_int_enable = r_item.write_data;
                            RG_IF:       n_int_flags  = r_item.write_data;
                            RG_SER_DATA: n_ser_data   = r_item.write_data;
                            RG_SER_CTRL: n_ser_ctrl   = r_item.write_data;
                            RG_DMA: begin
                                // start or restart the copy
                                n_dma_page    = r_item.write_data;
                                n_dma_running = 1'b1;
                                n_dma_index   = 8'h00;
                                n_dma_delay   = 2'(DMA_START_DELAY);
                            end
                            default:     n_out_data.error_code = ERR_UNSUPPORTED;
                        endcase
                    end else if (r_item.func == FN_TICK && r_dma_running) begin
                        if (r_dma_delay != 2'd0) begin
                            n_dma_delay = r_dma_delay - 2'd1;
                        end else begin
                            n_out_data.ext_target = w_rv_tgt;
                            n_out_data.error_code = w_rv_err;
                            if (w_rv_tgt != TGT_NONE) begin
                                n_out_data.ext_address = w_addr;
                            end
                            n_dma_index   = r_dma_index + 8'd1;
                            n_dma_running = (r_dma_index + 8'd1) < 8'(OAM_BYTES);
                        end
                    end

                    n_out_data.dma_busy           = n_dma_running;
                    n_out_data.dma_source_address = {n_dma_page, n_dma_index};
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_cnt     <= '0;
            r_out_valid   <= 1'b0;
            r_cart_att    <= 1'b1;
            r_sound_att   <= 1'b1;
            r_lcd_att     <= 1'b1;
            r_int_enable  <= 8'h00;
            r_int_flags   <= 8'h00;
            r_ser_data    <= 8'h00;
            r_ser_ctrl    <= 8'h00;
            r_dma_page    <= 8'h00;
            r_dma_running <= 1'b0;
            r_dma_index   <= 8'h00;
            r_dma_delay   <= 2'd0;
        end else begin
            r_state       <= n_state;
            r_clr_cnt     <= n_clr_cnt;
            r_out_valid   <= n_out_valid;
            r_int_enable  <= n_int_enable;
            r_int_flags   <= n_int_flags;
            r_ser_data    <= n_ser_data;
            r_ser_ctrl    <= n_ser_ctrl;
            r_dma_page    <= n_dma_page;
            r_dma_running <= n_dma_running;
            r_dma_index   <= n_dma_index;
            r_dma_delay   <= n_dma_delay;
            // presence bits, index 3 has no register
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CART:  r_cart_att  <= i_cfg_wdata;
                    CFG_SOUND: r_sound_att <= i_cfg_wdata;
                    CFG_LCD:   r_lcd_att   <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_item <= i_in_data;
        end
        r_out_data <= n_out_data;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the console memory map with object dma against a cycle-free shadow
//
// every accepted input beat runs through a shadow copy of all stores, the
// registers and the copy engine; the predicted result beat is queued and
// compared field by field with each result beat the block returns. stimulus
// is a short directed pass over the map, absent units and the copy engine,
// then random map traffic under several presence settings and random copy
// bursts with ticks, restarts and cpu traffic mixed in. both channels idle
// and stall at random for part of the run.
// ----------------------------------------------------------------------------
module testbench;
    import cmm_pkg::*;

    // fixed register addresses
    localparam logic [15:0] ADDR_SB   = 16'hFF01;
    localparam logic [15:0] ADDR_SC   = 16'hFF02;
    localparam logic [15:0] ADDR_IF   = 16'hFF0F;
    localparam logic [15:0] ADDR_DMA  = 16'hFF46;
    localparam logic [15:0] ADDR_IE   = 16'hFFFF;
    localparam logic [15:0] OAM_BASE  = 16'hFE00;
    localparam logic [15:0] HRAM_BASE = 16'hFF80;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_in_item   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_data;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = '0;
    logic       cfg_wdata = 1'b0;

    // shadow of the block state
    logic [7:0] vram_shadow [VRAM_BYTES];
    logic [7:0] wram_shadow [WRAM_BYTES];
    logic [7:0] hram_shadow [HRAM_BYTES];
    logic [7:0] oam_shadow  [OAM_BYTES];
    logic [7:0] ie_shadow;
    logic [7:0] if_shadow;
    logic [7:0] sb_shadow;
    logic [7:0] sc_shadow;
    logic [7:0] copy_page;
    logic       copy_on;
    logic [7:0] copy_index;
    logic [1:0] copy_wait;
    logic       cart_on;
    logic       sound_on;
    logic       lcd_on;

    t_out_item pending_bus_results [$];
    int        bad_fields      = 0;
    int        effective_items = 0;
    int        gap_max         = 0;
    int        stall_max       = 0;
    int        stall_left      = 0;

    console_memory_map_with_oam_dma dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------

    task automatic clear_shadow();
        foreach (vram_shadow[i]) vram_shadow[i] = 8'h00;
        foreach (wram_shadow[i]) wram_shadow[i] = 8'h00;
        foreach (hram_shadow[i]) hram_shadow[i] = 8'h00;
        foreach (oam_shadow[i]) oam_shadow[i] = 8'h00;
        ie_shadow  = 8'h00;
        if_shadow  = 8'h00;
        sb_shadow  = 8'h00;
        sc_shadow  = 8'h00;
        copy_page  = 8'h00;
        copy_on    = 1'b0;
        copy_index = 8'h00;
        copy_wait  = 2'd0;
        cart_on    = 1'b1;
        sound_on   = 1'b1;
        lcd_on     = 1'b1;
    endtask

    // external unit behind an address, with its presence
    function automatic t_target ext_owner(input logic [15:0] a, output logic present);
        present = 1'b1;
        if (a < 16'h8000 || (a >= 16'hA000 && a < 16'hC000)) begin
            present = cart_on;
            return TGT_CART;
        end
        if (a == 16'hFF00) return TGT_PAD;
        if (a >= 16'hFF04 && a <= 16'hFF07) return TGT_TIMER;
        if (a >= 16'hFF10 && a <= 16'hFF26) begin
            present = sound_on;
            return TGT_SOUND;
        end
        if (a >= 16'hFF30 && a <= 16'hFF3F) begin
            present = sound_on;
            return TGT_WAVE;
        end
        // the copy page register sits inside the lcd block but is local
        if (a >= 16'hFF40 && a <= 16'hFF4B && a != ADDR_DMA) begin
            present = lcd_on;
            return TGT_LCD;
        end
        return TGT_NONE;
    endfunction

    function automatic logic [7:0] shadow_read(input logic [15:0] a, input logic [7:0] ext,
                                               output t_target tgt, output t_err err);
        logic    present;
        t_target owner;
        owner = ext_owner(a, present);
        tgt = TGT_NONE;
        err = ERR_OK;
        if (owner != TGT_NONE) begin
            if (!present) begin
                err = ERR_ABSENT;
                return BYTE_ONES;
            end
            tgt = owner;
            return ext;
        end
        if (a >= 16'h8000 && a < 16'hA000) return vram_shadow[a[12:0]];
        if (a >= 16'hC000 && a < 16'hE000) return wram_shadow[a[12:0]];
        if (a >= OAM_BASE && a < OAM_BASE + OAM_BYTES) begin
            // cpu is locked out of object ram while a copy runs
            if (copy_on) return BYTE_ONES;
            return oam_shadow[a[7:0]];
        end
        if (a == ADDR_IE) return ie_shadow;
        if (a >= HRAM_BASE) begin
            if (a[6:0] < HRAM_BYTES) return hram_shadow[a[6:0]];
            err = ERR_UNSUPPORTED;
            return 8'h00;
        end
        if (a == ADDR_SB) return sb_shadow;
        if (a == ADDR_SC) return sc_shadow;
        if (a == ADDR_IF) return if_shadow;
        if (a == ADDR_DMA) return copy_page;
        // echo ram, reserved area and unknown i/o
        err = ERR_UNSUPPORTED;
        return 8'h00;
    endfunction

    function automatic void shadow_write(input logic [15:0] a, input logic [7:0] v,
                                         output t_target tgt, output logic fwd,
                                         output t_err err);
        logic    present;
        t_target owner;
        owner = ext_owner(a, present);
        tgt = TGT_NONE;
        fwd = 1'b0;
        err = ERR_OK;
        if (owner != TGT_NONE) begin
            if (!present) begin
                err = ERR_ABSENT;
                return;
            end
            tgt = owner;
            fwd = 1'b1;
        end else if (a >= 16'h8000 && a < 16'hA000) begin
            vram_shadow[a[12:0]] = v;
        end else if (a >= 16'hC000 && a < 16'hE000) begin
            wram_shadow[a[12:0]] = v;
        end else if (a >= OAM_BASE && a < OAM_BASE + OAM_BYTES) begin
            if (!copy_on) oam_shadow[a[7:0]] = v;
        end else if (a == ADDR_IE) begin
            ie_shadow = v;
        end else if (a >= HRAM_BASE) begin
            if (a[6:0] < HRAM_BYTES) hram_shadow[a[6:0]] = v;
            else err = ERR_UNSUPPORTED;
        end else if (a == ADDR_SB) begin
            sb_shadow = v;
        end else if (a == ADDR_SC) begin
            sc_shadow = v;
        end else if (a == ADDR_IF) begin
            if_shadow = v;
        end else if (a == ADDR_DMA) begin
            // starts a copy, or restarts one already running
            copy_page  = v;
            copy_on    = 1'b1;
            copy_index = 8'h00;
            copy_wait  = 2'(DMA_START_DELAY & 3);
        end else begin
            err = ERR_UNSUPPORTED;
        end
    endfunction

    // advances the shadow by one beat and returns the result it causes
    function automatic t_out_item predict_bus_result(input t_in_item it);
        t_out_item   r;
        t_target     tgt;
        t_err        err;
        logic        fwd;
        logic [15:0] src;
        logic [7:0]  copied;
        r   = '0;
        tgt = TGT_NONE;
        err = ERR_OK;
        fwd = 1'b0;
        case (it.func)
            FN_READ: begin
                r.read_data = shadow_read(it.address, it.ext_data, tgt, err);
                if (tgt != TGT_NONE) r.ext_address = it.address;
            end
            FN_WRITE: begin
                shadow_write(it.address, it.write_data, tgt, fwd, err);
                if (fwd) begin
                    r.ext_address    = it.address;
                    r.ext_write_data = it.write_data;
                end
            end
            FN_TICK: begin
                if (copy_on) begin
                    if (copy_wait != 2'd0) begin
                        copy_wait = copy_wait - 2'd1;
                    end else begin
                        // source decoded as a cpu read with the copy running
                        src    = {copy_page, copy_index};
                        copied = shadow_read(src, it.ext_data, tgt, err);
                        if (tgt != TGT_NONE) r.ext_address = src;
                        oam_shadow[copy_index] = copied;
                        copy_index = copy_index + 8'd1;
                        copy_on    = (copy_index < OAM_BYTES);
                    end
                end
            end
            default: ;
        endcase
        r.ext_target         = tgt;
        r.ext_write          = fwd;
        r.dma_busy           = copy_on;
        r.dma_source_address = {copy_page, copy_index};
        r.error_code         = err;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking and receiver stalls
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            bad_fields++;
        end
    endtask

    always @(posedge clk) begin : check_beat
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_bus_results.size() == 0) begin
                $error("result beat with no expectation waiting: %h", out_data);
                bad_fields++;
            end else begin
                want = pending_bus_results.pop_front();
                check_field("read_data", 16'(want.read_data), 16'(out_data.read_data));
                check_field("ext_target", 16'(want.ext_target), 16'(out_data.ext_target));
                check_field("ext_write", 16'(want.ext_write), 16'(out_data.ext_write));
                check_field("ext_address", want.ext_address, out_data.ext_address);
                check_field("ext_write_data", 16'(want.ext_write_data),
                            16'(out_data.ext_write_data));
                check_field("dma_busy", 16'(want.dma_busy), 16'(out_data.dma_busy));
                check_field("dma_source_address", want.dma_source_address,
                            out_data.dma_source_address);
                check_field("error_code", 16'(want.error_code), 16'(out_data.error_code));
            end
        end
    end

    // after each taken result beat, hold off the next for a random count
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else if (out_valid && !out_stall) begin
            stall_left = $urandom_range(stall_max, 0);
            out_stall <= (stall_left != 0);
        end else if (stall_left != 0) begin
            stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // called at a rising edge; returns at the edge that takes the beat
    task automatic send_item(input t_in_item it);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        // no-ops and ticks with no copy running leave the block untouched
        if (!(it.func == FN_NOP || (it.func == FN_TICK && !copy_on))) effective_items++;
        pending_bus_results.push_back(predict_bus_result(it));
    endtask

    // drop valid and let every expected result come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_bus_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // writes all three presence registers on consecutive cycles
    task automatic set_presence(input logic cart, input logic sound, input logic lcd);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CART;
        cfg_wdata <= cart;
        @(posedge clk);
        cfg_index <= CFG_SOUND;
        cfg_wdata <= sound;
        @(posedge clk);
        cfg_index <= CFG_LCD;
        cfg_wdata <= lcd;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cart_on  = cart;
        sound_on = sound;
        lcd_on   = lcd;
    endtask

    function automatic t_in_item make_item(input t_func f, input logic [15:0] a,
                                           input logic [7:0] wd);
        t_in_item it;
        it.func       = f;
        it.address    = a;
        it.write_data = wd;
        it.ext_data   = 8'($urandom);
        return it;
    endfunction

    // region-weighted address; ram windows are narrow so reads hit writes
    function automatic logic [15:0] pick_address();
        logic [15:0] a;
        a = 16'($urandom);
        case ($urandom_range(11, 0))
            0: a = {1'b0, a[14:0]};
            1: a = {3'b100, a[15] ? a[12:0] : {9'b0, a[3:0]}};
            2: a = {3'b101, a[12:0]};
            3: a = {3'b110, a[15] ? a[12:0] : {9'b0, a[3:0]}};
            4: a = 16'hE000 + 16'(a % 16'h1E00);
            5: a = OAM_BASE | 16'(a[7:0] % 8'd160);
            6: a = {8'hFE, 8'hA0 + 8'(a[7:0] % 8'd96)};
            7, 8: a = {9'h1FE, a[6:0]};
            9: begin
                case (a[2:0])
                    3'd0: a = ADDR_SB;
                    3'd1: a = ADDR_SC;
                    3'd2: a = ADDR_IF;
                    3'd3: a = ADDR_IE;
                    3'd4: a = ADDR_DMA;
                    3'd5: a = HRAM_BASE;
                    3'd6: a = 16'hFFFE;
                    default: a = 16'hFE9F;
                endcase
            end
            10: a = {9'h1FF, 7'(a[6:0] % 7'd127)};
            default: ;
        endcase
        return a;
    endfunction

    function automatic t_in_item random_access();
        int r;
        r = $urandom_range(99, 0);
        if (r < 40) return make_item(FN_READ, pick_address(), 8'($urandom));
        if (r < 80) return make_item(FN_WRITE, pick_address(), 8'($urandom));
        if (r < 92) return make_item(FN_TICK, 16'($urandom), 8'($urandom));
        return make_item(FN_NOP, 16'($urandom), 8'($urandom));
    endfunction

    // copy source page: every region kind, ram pages with written data
    function automatic logic [7:0] pick_page();
        logic [7:0] p;
        p = 8'($urandom);
        case ($urandom_range(7, 0))
            0: p = {1'b0, p[6:0]};
            1: p = {3'b101, p[4:0]};
            2: p = p[7] ? 8'h80 : {3'b100, p[4:0]};
            3: p = p[7] ? 8'hC0 : {3'b110, p[4:0]};
            4: p = 8'hFE;
            5: p = 8'hFF;
            6: p = 8'hE0 + 8'(p % 8'd30);
            default: ;
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // vram, wram and hram stores, the ie, if and serial data registers, each external
    // unit, the unsupported regions, a no-op and a tick with no copy running
    task automatic test_map_directed();
        set_presence(1'b1, 1'b1, 1'b1);
        send_item(make_item(FN_WRITE, 16'h8000, 8'hFF));
        send_item(make_item(FN_READ,  16'h8000, 8'h00));
        send_item(make_item(FN_WRITE, 16'hDFFF, 8'h01));
        send_item(make_item(FN_READ,  16'hDFFF, 8'h00));
        send_item(make_item(FN_WRITE, 16'hFFFE, 8'h80));
        send_item(make_item(FN_READ,  16'hFFFE, 8'h00));
        send_item(make_item(FN_WRITE, ADDR_IE,  8'h1F));
        send_item(make_item(FN_WRITE, ADDR_IF,  8'hE1));
        send_item(make_item(FN_READ,  ADDR_SB,  8'h00));
        send_item(make_item(FN_READ,  16'h0000, 8'h00));
        send_item(make_item(FN_WRITE, 16'h7FFF, 8'hAA));
        send_item(make_item(FN_READ,  16'hFF00, 8'h00));
        send_item(make_item(FN_WRITE, 16'hFF07, 8'h55));
        send_item(make_item(FN_READ,  16'hFF26, 8'h00));
        send_item(make_item(FN_READ,  16'hFF30, 8'h00));
        send_item(make_item(FN_WRITE, 16'hFF4B, 8'h3C));
        send_item(make_item(FN_READ,  16'hE000, 8'h00));
        send_item(make_item(FN_WRITE, 16'hFEA0, 8'h99));
        send_item(make_item(FN_READ,  16'hFF03, 8'h00));
        send_item(make_item(FN_NOP,   16'hFFFF, 8'hFF));
        send_item(make_item(FN_TICK,  16'h1234, 8'h00));
    endtask

    // absent units read as all ones and drop writes
    task automatic test_absent_units();
        wait_idle();
        set_presence(1'b0, 1'b0, 1'b0);
        send_item(make_item(FN_READ,  16'h4000, 8'h00));
        send_item(make_item(FN_WRITE, 16'hA123, 8'h42));
        send_item(make_item(FN_READ,  16'hFF3F, 8'h00));
        send_item(make_item(FN_READ,  16'hFF40, 8'h00));
    endtask

    // start delay, object ram lockout, first copied byte and a restart
    task automatic test_copy_directed();
        wait_idle();
        set_presence(1'b1, 1'b1, 1'b1);
        send_item(make_item(FN_WRITE, OAM_BASE, 8'h11));
        send_item(make_item(FN_WRITE, ADDR_DMA, 8'hC0));
        send_item(make_item(FN_READ,  OAM_BASE, 8'h00));
        send_item(make_item(FN_WRITE, 16'hFE01, 8'h22));
        send_item(make_item(FN_TICK,  16'h0000, 8'h00));
        send_item(make_item(FN_TICK,  16'h0000, 8'h00));
        send_item(make_item(FN_TICK,  16'h0000, 8'h00));
        send_item(make_item(FN_WRITE, ADDR_DMA, 8'hC0));
        send_item(make_item(FN_TICK,  16'h0000, 8'h00));
    endtask

    // random map traffic under several presence settings and idle patterns
    task automatic test_map_random();
        int         target;
        logic [2:0] presence;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: presence = 3'b111;
                1: presence = 3'b000;
                2: presence = 3'b101;
                3: presence = 3'b010;
                default: presence = 3'($urandom_range(7, 0));
            endcase
            wait_idle();
            set_presence(presence[2], presence[1], presence[0]);
            gap_max   = (phase == 1 || phase == 3) ? 0 : 11;
            stall_max = (phase == 1 || phase == 2) ? 0 : 11;
            target = effective_items + 125;
            while (effective_items < target) send_item(random_access());
        end
    endtask

    // copy bursts: start, mostly ticks with cpu traffic and rare restarts,
    // some cut short; six object ram entries read back after each burst
    task automatic test_copy_random();
        int target;
        int steps;
        int limit;
        int r;
        target = effective_items + 1100;
        while (effective_items < target) begin
            if ($urandom_range(2, 0) == 0) begin
                wait_idle();
                set_presence(1'($urandom), 1'($urandom), 1'($urandom));
            end
            gap_max   = ($urandom_range(3, 0) == 0) ? 0 : 11;
            stall_max = ($urandom_range(3, 0) == 0) ? 0 : 11;
            send_item(make_item(FN_WRITE, ADDR_DMA, pick_page()));
            limit = ($urandom_range(4, 0) == 0) ? $urandom_range(100, 5) : 400;
            steps = 0;
            while (copy_on && steps < limit) begin
                r = $urandom_range(99, 0);
                if (r < 70) send_item(make_item(FN_TICK, 16'($urandom), 8'($urandom)));
                else if (r < 71) send_item(make_item(FN_WRITE, ADDR_DMA, pick_page()));
                else send_item(random_access());
                steps++;
            end
            for (int k = 0; k < 6; k++) begin
                send_item(make_item(FN_READ, OAM_BASE | 16'($urandom_range(159, 0)),
                                    8'h00));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------

    initial begin
        clear_shadow();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // the block clears its stores first; beats wait on the stall
        test_map_directed();
        test_absent_units();
        test_copy_directed();
        test_map_random();
        test_copy_random();
        wait_idle();
        repeat (20) @(posedge clk);
        if (bad_fields == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- console_memory_map_with_oam_dma.f -----
hdl/cmm_pkg.sv
hdl/cmm_ram.sv
hdl/cmm_decode.sv
hdl/console_memory_map_with_oam_dma.sv
dv/testbench.sv
